### rtl/gb3_pkg.sv
// shared types and constants for the 3x3 gaussian blur
// no dependencies

package gb3_pkg;

  localparam int PIX_W = 8;

  // default sizes of the line buffers and of the row counter
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // configuration register widths, reset values and indexes
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // result queue depth, a power of two
  localparam int FIFO_DEPTH = 8;

  typedef logic [PIX_W-1:0] pix_t;

  // one window column, top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // one result word
  typedef struct packed {
    pix_t pixel;
    logic row_end;
    logic frame_end;
  } res_t;

  // clamp a frame dimension to 2..hi
  function automatic logic [31:0] clamp_dim(input logic [31:0] raw, input logic [31:0] hi);
    logic [31:0] res;
    res = raw;
    if (raw < 32'd2) begin
      res = 32'd2;
    end else if (raw > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

### rtl/gb3_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/gb3_col_cell.sv
// one column of the 3x3 window, loaded with the new column or from its right-hand neighbor
// depends on gb3_pkg

module gb3_col_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  gb3_pkg::col_t col_in,
  output gb3_pkg::col_t col_out
);

  import gb3_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

### rtl/gb3_fifo.sv
// small result queue that decouples the pipeline from output stalls
// depends on gb3_pkg

module gb3_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  gb3_pkg::res_t                     push_data,
  input  logic                              pop,
  output logic                              not_empty,
  output gb3_pkg::res_t                     head,
  output logic [$clog2(gb3_pkg::FIFO_DEPTH+1)-1:0] count
);

  import gb3_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  res_t            mem_r [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

### rtl/gaussian_blur_3x3_top.sv
// top level of the 3x3 gaussian blur (weights 1-2-1 / 2-4-2 / 1-2-1, divided by 16)
// depends on gb3_pkg, gb3_ram, gb3_col_cell and gb3_fifo

// Streams 8-bit grey pixels in raster order and returns one blurred pixel
// per position, computed as floor((4*centre + 2*edges)/16) + floor(corners/16)
// with neighbors outside the frame taken as zero. The block takes one word
// per clock while in_stall is low: the window is a chain of three column
// cells that shift on every accepted pixel, and the two line buffers are rams
// that do one read and one write per pixel. A result is released by the word
// taken frame_width+1 words after the pixel at its position; after that word
// is taken the ram read happens at the accepting edge, then come the window
// shift, the partial sums and the result queue write. Drain words act
// as zero pixels to push the last row out; a drain while the pipeline is empty
// is taken and dropped, and the drain that yields the frame_end result empties
// the stream. Writing frame_width or frame_height restarts the stream. An
// eight-word result queue absorbs output stalls; in_stall rises only when that
// queue and the words in flight could fill it. The line buffers need no
// clearing after reset, since stale entries never reach an unmasked window place.

module gaussian_blur_3x3_top #(
  parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  // pixel input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_pixel_in,
  input  logic               in_drain,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_pixel_out,
  output logic               out_row_end,
  output logic               out_frame_end,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import gb3_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int LagW = $clog2(MAX_WIDTH + 2);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam int OccW = CntW + 1;

  localparam logic [31:0] W_EFF_RST =
    clamp_dim({21'd0, FRAME_WIDTH_RST}, 32'(MAX_WIDTH));
  localparam logic [31:0] H_EFF_RST =
    clamp_dim({19'd0, FRAME_HEIGHT_RST}, 32'(MAX_HEIGHT));

  // border flags and end marks carried along with a pixel
  typedef struct packed {
    logic t;
    logic b;
    logic l;
    logic r;
    logic row_end;
    logic frame_end;
  } msk_t;

  // ---------------------------------------------------------------------------
  // configuration registers, with the clamped sizes kept ready for use
  // ---------------------------------------------------------------------------
  logic                      cfg_wr;
  logic [FRAME_WIDTH_W-1:0]  frame_width_r;
  logic [FRAME_WIDTH_W-1:0]  frame_width_nxt;
  logic [FRAME_HEIGHT_W-1:0] frame_height_r;
  logic [FRAME_HEIGHT_W-1:0] frame_height_nxt;
  logic [31:0]               w_eff;
  logic [31:0]               h_eff;
  logic [ColW-1:0]           w_m1_r;      // last column index
  logic [ColW-1:0]           w_m1_nxt;
  logic [LagW-1:0]           lag_tgt_r;   // fill depth at which results start
  logic [LagW-1:0]           lag_tgt_nxt;
  logic [RowW-1:0]           h_m1_r;      // last row index
  logic [RowW-1:0]           h_m1_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = pwdata[FRAME_HEIGHT_W-1:0];
        default:          frame_width_nxt  = frame_width_r;
      endcase
    end
    w_eff       = clamp_dim({21'd0, frame_width_nxt}, 32'(MAX_WIDTH));
    h_eff       = clamp_dim({19'd0, frame_height_nxt}, 32'(MAX_HEIGHT));
    w_m1_nxt    = ColW'(w_eff - 32'd1);
    lag_tgt_nxt = LagW'(w_eff + 32'd1);
    h_m1_nxt    = RowW'(h_eff - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      w_m1_r         <= ColW'(W_EFF_RST - 32'd1);
      lag_tgt_r      <= LagW'(W_EFF_RST + 32'd1);
      h_m1_r         <= RowW'(H_EFF_RST - 32'd1);
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      w_m1_r         <= w_m1_nxt;
      lag_tgt_r      <= lag_tgt_nxt;
      h_m1_r         <= h_m1_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {21'd0, frame_width_r};
      REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_r};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // input stage: stream counters and line buffer read
  // ---------------------------------------------------------------------------
  logic            accept;
  logic            step;        // accepted word that moves the pipeline
  logic            emit;        // this word releases a result
  logic            last_col;
  logic            last_row;
  logic            restart;     // drain that finishes the frame
  logic            started_r;
  logic            started_nxt;
  logic [ColW-1:0] in_col_r;
  logic [ColW-1:0] in_col_nxt;
  logic [LagW-1:0] lag_r;       // words in the window and line buffers
  logic [LagW-1:0] lag_nxt;
  logic [ColW-1:0] out_col_r;
  logic [ColW-1:0] out_col_nxt;
  logic [RowW-1:0] out_row_r;
  logic [RowW-1:0] out_row_nxt;
  msk_t            msk;

  assign accept   = in_valid && !in_stall;
  assign step     = accept && !(in_drain && !started_r);
  assign emit     = (lag_r == lag_tgt_r);
  assign last_col = (out_col_r == w_m1_r);
  assign last_row = (out_row_r == h_m1_r);
  assign restart  = step && emit && last_col && last_row && in_drain;

  always_comb begin
    msk.t         = (out_row_r != '0);
    msk.b         = !last_row;
    msk.l         = (out_col_r != '0);
    msk.r         = !last_col;
    msk.row_end   = last_col;
    msk.frame_end = last_col && last_row;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    lag_nxt     = lag_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    started_nxt = started_r;
    if (cfg_wr) begin
      in_col_nxt  = '0;
      lag_nxt     = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      started_nxt = 1'b0;
    end else if (step) begin
      started_nxt = 1'b1;
      in_col_nxt  = (in_col_r == w_m1_r) ? '0 : in_col_r + ColW'(1);
      if (!emit) begin
        lag_nxt = lag_r + LagW'(1);
      end else begin
        out_col_nxt = last_col ? '0 : out_col_r + ColW'(1);
        if (last_col) begin
          out_row_nxt = last_row ? '0 : out_row_r + RowW'(1);
        end
      end
      // frame fully drained: back to an empty stream
      if (restart) begin
        in_col_nxt  = '0;
        lag_nxt     = '0;
        started_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      lag_r     <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      started_r <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      lag_r     <= lag_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      started_r <= started_nxt;
    end
  end

  // stage 1 carries the pixel while the line buffers are read
  logic            s1_v_r;
  logic            s1_emit_r;
  pix_t            s1_px_r;
  logic [ColW-1:0] s1_col_r;
  msk_t            s1_msk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
    end else begin
      s1_v_r    <= step;
      s1_emit_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_px_r  <= in_drain ? '0 : in_pixel_in;
      s1_col_r <= in_col_r;
      s1_msk_r <= msk;
    end
  end

  pix_t up_rd;
  pix_t mid_rd;

  // upper line takes what leaves the middle line
  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (step),
    .raddr (in_col_r),
    .rdata (up_rd)
  );

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (step),
    .raddr (in_col_r),
    .rdata (mid_rd)
  );

  // ---------------------------------------------------------------------------
  // window: three column cells, new column enters on the right
  // ---------------------------------------------------------------------------
  col_t new_col;
  col_t win_col [3];   // 0 left, 1 centre, 2 right

  assign new_col = '{top: up_rd, mid: mid_rd, bot: s1_px_r};

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_cell
      if (k == 2) begin : g_right
        gb3_col_cell u_cell (
          .clk      (clk),
          .shift_en (s1_v_r),
          .col_in   (new_col),
          .col_out  (win_col[k])
        );
      end else begin : g_inner
        gb3_col_cell u_cell (
          .clk      (clk),
          .shift_en (s1_v_r),
          .col_in   (win_col[k+1]),
          .col_out  (win_col[k])
        );
      end
    end
  endgenerate

  // stage 2 holds the border flags of the result now in the window
  logic s2_e_r;
  msk_t s2_msk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_e_r <= 1'b0;
    end else begin
      s2_e_r <= s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_msk_r <= s1_msk_r;
    end
  end

  // masked partial sums
  logic [9:0]  edge_sum;
  logic [9:0]  corner_sum;
  logic [11:0] ec_sum;

  always_comb begin
    edge_sum   = '0;
    corner_sum = '0;
    if (s2_msk_r.t) edge_sum = edge_sum + {2'd0, win_col[1].top};
    if (s2_msk_r.b) edge_sum = edge_sum + {2'd0, win_col[1].bot};
    if (s2_msk_r.l) edge_sum = edge_sum + {2'd0, win_col[0].mid};
    if (s2_msk_r.r) edge_sum = edge_sum + {2'd0, win_col[2].mid};
    if (s2_msk_r.t && s2_msk_r.l) corner_sum = corner_sum + {2'd0, win_col[0].top};
    if (s2_msk_r.t && s2_msk_r.r) corner_sum = corner_sum + {2'd0, win_col[2].top};
    if (s2_msk_r.b && s2_msk_r.l) corner_sum = corner_sum + {2'd0, win_col[0].bot};
    if (s2_msk_r.b && s2_msk_r.r) corner_sum = corner_sum + {2'd0, win_col[2].bot};
    ec_sum = {2'd0, win_col[1].mid, 2'd0} + {1'b0, edge_sum, 1'b0};
  end

  // stage 3: registered sums, then the final add into the queue
  logic        s3_e_r;
  logic [11:0] s3_ec_r;
  logic [9:0]  s3_co_r;
  logic        s3_row_end_r;
  logic        s3_frame_end_r;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_e_r <= 1'b0;
    end else begin
      s3_e_r <= s2_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_e_r) begin
      s3_ec_r        <= ec_sum;
      s3_co_r        <= corner_sum;
      s3_row_end_r   <= s2_msk_r.row_end;
      s3_frame_end_r <= s2_msk_r.frame_end;
    end
  end

  assign res.pixel     = s3_ec_r[11:4] + {2'd0, s3_co_r[9:4]};
  assign res.row_end   = s3_row_end_r;
  assign res.frame_end = s3_frame_end_r;

  // ---------------------------------------------------------------------------
  // result queue and flow control
  // ---------------------------------------------------------------------------
  logic            pop;
  res_t            head;
  logic [CntW-1:0] fifo_cnt;
  logic [OccW-1:0] occ;   // results queued or still in flight

  assign pop = out_valid && !out_stall;

  gb3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_e_r),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (fifo_cnt)
  );

  assign out_pixel_out = head.pixel;
  assign out_row_end   = head.row_end;
  assign out_frame_end = head.frame_end;

  assign occ = {{(OccW-1){1'b0}}, s1_emit_r} + {{(OccW-1){1'b0}}, s2_e_r}
             + {{(OccW-1){1'b0}}, s3_e_r} + {1'b0, fifo_cnt};
  assign in_stall = (occ >= OccW'(FIFO_DEPTH));

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OccW'(FIFO_DEPTH))
    else $error("result queue overcommitted");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lag_r <= lag_tgt_r)
    else $error("fill depth ran past the window lag");

  a_drain_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (!started_r && lag_r == '0 && in_col_r == '0))
    else $error("final drain did not empty the stream");

endmodule

### dv/gaussian_blur_3x3_top_tb.sv
// self-checking testbench for gaussian_blur_3x3_top: directed rows, then random frames
// depends on gb3_pkg and the gaussian_blur_3x3_top rtl

module gaussian_blur_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  // cycles with no word moving on any port before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // pipeline depth plus margin, waited out before a register write and at the end
  localparam int SETTLE_CYCLES = 16;
  localparam int N_DIRECTED = 24;
  localparam int N_PHASES = 8;
  localparam res_t RES_NONE = '0;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_e;

  typedef struct packed {
    pix_t pix;
    logic drn;
    chk_e kind;
    res_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pixel_in = '0;
  logic        in_drain = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pixel_out;
  logic        out_row_end;
  logic        out_frame_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gaussian_blur_3x3_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .in_drain      (in_drain),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // blur predictor: own copy of registers, line buffers, window and counters
  // ---------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0]  fw_reg;
  logic [FRAME_HEIGHT_W-1:0] fh_reg;
  pix_t        upper_row [MAX_W];
  pix_t        middle_row [MAX_W];
  // window places 0..8: rows top to bottom, columns left to right
  pix_t        win [9];
  int unsigned in_col, in_row, out_col, out_row;
  bit          primed;

  // blurred words still owed by the block, oldest first
  res_t        blurred_q [$];
  int unsigned words_fed;
  int unsigned fails;

  // register values as the block uses them, clamped to 2..max
  function automatic int unsigned frame_w();
    if (fw_reg < 2) return 2;
    if (fw_reg > MAX_W) return MAX_W;
    return 32'(fw_reg);
  endfunction

  function automatic int unsigned frame_h();
    if (fh_reg < 2) return 2;
    if (fh_reg > MAX_H) return MAX_H;
    return 32'(fh_reg);
  endfunction

  // any register write, or the frame-ending drain, empties the stream
  function automatic void restart_stream();
    foreach (win[k]) win[k] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    primed = 1'b0;
  endfunction

  // advance the predictor by one accepted word; returns 1 when a result leaves
  function automatic bit blur_predict(input pix_t pix, input logic drn, output res_t r);
    int unsigned w, h, total, in_pos, out_pos, col, centre, edges, corners, value;
    pix_t px;
    bit emit, t, b, l, rt;
    w = frame_w();
    h = frame_h();
    total = w * h;
    px = drn ? '0 : pix;
    r = RES_NONE;
    // idle drain: nothing in flight, nothing happens
    if (drn && !primed) return 1'b0;
    primed = 1'b1;

    in_pos = in_row * w + in_col;
    out_pos = out_row * w + out_col;
    emit = ((in_pos + total - out_pos) % total) == w + 1;

    // shift the window left and load the new column from the line buffers
    col = in_col % MAX_W;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = upper_row[col];
    win[5] = middle_row[col];
    win[8] = px;
    upper_row[col] = middle_row[col];
    middle_row[col] = px;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end

    if (!emit) return 1'b0;

    // border masks: neighbors outside the frame count as zero
    t = out_row > 0;
    b = out_row + 1 < h;
    l = out_col > 0;
    rt = out_col + 1 < w;
    centre = 32'(win[4]);
    edges = 0;
    corners = 0;
    if (t) edges += 32'(win[1]);
    if (b) edges += 32'(win[7]);
    if (l) edges += 32'(win[3]);
    if (rt) edges += 32'(win[5]);
    if (t && l) corners += 32'(win[0]);
    if (t && rt) corners += 32'(win[2]);
    if (b && l) corners += 32'(win[6]);
    if (b && rt) corners += 32'(win[8]);
    value = (4 * centre + 2 * edges) / 16 + corners / 16;

    r.pixel = value[7:0];
    r.row_end = !rt;
    r.frame_end = !rt && !b;

    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    if (r.frame_end && drn) restart_stream();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // idle lengths: mostly none or short, a few long, and calm stretches
  // ---------------------------------------------------------------------------
  int unsigned calm_in, calm_out, stall_left;

  function automatic int unsigned pick_idle(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if (r < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // grey level with the extremes favored
  function automatic pix_t rand_pix();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return pix_t'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // pixel side: predict, then hold the word until it is taken
  // ---------------------------------------------------------------------------
  task automatic feed_word(input pix_t pix, input logic drn, input chk_e kind,
                           input res_t want);
    res_t r;
    bit got;
    int unsigned gap;
    if (!(drn && !primed)) words_fed++;
    got = blur_predict(pix, drn, r);
    case (kind)
      CHK_MODEL: begin
        if (got) blurred_q.push_back(r);
      end
      CHK_GIVEN: begin
        blurred_q.push_back(want);
      end
      default: begin
      end
    endcase
    gap = pick_idle(calm_in);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    in_drain <= drn;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, let every owed word come out, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register port: write, then read back the stored bits
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic idx, input logic [31:0] value);
    logic [31:0] stored;
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // the write lands here and restarts the stream
    if (idx == REG_FRAME_WIDTH) begin
      fw_reg = value[FRAME_WIDTH_W-1:0];
      stored = 32'(fw_reg);
    end else begin
      fh_reg = value[FRAME_HEIGHT_W-1:0];
      stored = 32'(fh_reg);
    end
    restart_stream();
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $display("%0t: register %0d read expected %0h actual %0h", $time, idx, stored, prdata);
      fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // random phase: mostly whole frames with random content, some noise
  // ---------------------------------------------------------------------------
  task automatic run_phase(input int unsigned budget);
    int unsigned start, total, n, pick;
    total = frame_w() * frame_h();
    start = words_fed;
    while (words_fed - start < budget) begin
      pick = $urandom_range(0, 99);
      if (total > 400) begin
        // frame too big to finish: a plain stream with the odd early drain
        feed_word(rand_pix(), $urandom_range(0, 99) < 5, CHK_MODEL, RES_NONE);
      end else if (pick < 55) begin
        // whole frame, then drains until the frame end empties the stream
        repeat (total) feed_word(rand_pix(), 1'b0, CHK_MODEL, RES_NONE);
        while (primed) feed_word(rand_pix(), 1'b1, CHK_MODEL, RES_NONE);
        // sometimes an idle drain on top
        if ($urandom_range(0, 3) == 0) feed_word(rand_pix(), 1'b1, CHK_MODEL, RES_NONE);
      end else if (pick < 75) begin
        // whole frame, next one follows with no drain
        repeat (total) feed_word(rand_pix(), 1'b0, CHK_MODEL, RES_NONE);
      end else if (pick < 90) begin
        // cut-short frame with early drains, then flushed
        n = $urandom_range(1, total - 1);
        repeat (n) feed_word(rand_pix(), $urandom_range(0, 99) < 20, CHK_MODEL, RES_NONE);
        while (primed) feed_word(rand_pix(), 1'b1, CHK_MODEL, RES_NONE);
      end else begin
        // noise: pixels and drains mixed freely
        n = $urandom_range(1, 2 * frame_w());
        repeat (n) feed_word(rand_pix(), $urandom_range(0, 99) < 40, CHK_MODEL, RES_NONE);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed rows, run on a 2x2 frame (width 0 and height 1 clamp up to 2)
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [N_DIRECTED] = '{
    // all-zero frame: results are zero, flags read off the raster position
    '{8'h00, 1'b0, CHK_NONE,  RES_NONE},
    '{8'h00, 1'b0, CHK_NONE,  RES_NONE},
    '{8'h00, 1'b0, CHK_NONE,  RES_NONE},
    '{8'h00, 1'b0, CHK_GIVEN, {8'h00, 1'b0, 1'b0}},
    // drains flush the tail, the pixel field on a drain is ignored
    '{8'h9c, 1'b1, CHK_GIVEN, {8'h00, 1'b1, 1'b0}},
    '{8'h00, 1'b1, CHK_GIVEN, {8'h00, 1'b0, 1'b0}},
    '{8'hff, 1'b1, CHK_GIVEN, {8'h00, 1'b1, 1'b1}},
    // drain with the stream empty gives nothing
    '{8'h5a, 1'b1, CHK_NONE,  RES_NONE},
    // full-scale frame
    '{8'hff, 1'b0, CHK_MODEL, RES_NONE},
    '{8'hff, 1'b0, CHK_MODEL, RES_NONE},
    '{8'hff, 1'b0, CHK_MODEL, RES_NONE},
    '{8'hff, 1'b0, CHK_MODEL, RES_NONE},
    // next frame straight behind it, alternating bit patterns
    '{8'h55, 1'b0, CHK_MODEL, RES_NONE},
    '{8'haa, 1'b0, CHK_MODEL, RES_NONE},
    '{8'h01, 1'b0, CHK_MODEL, RES_NONE},
    '{8'h80, 1'b0, CHK_MODEL, RES_NONE},
    // third frame with drains standing in for pixels
    '{8'h7f, 1'b0, CHK_MODEL, RES_NONE},
    '{8'h00, 1'b1, CHK_MODEL, RES_NONE},
    '{8'hfe, 1'b0, CHK_MODEL, RES_NONE},
    '{8'h3c, 1'b1, CHK_MODEL, RES_NONE},
    '{8'h00, 1'b1, CHK_MODEL, RES_NONE},
    '{8'hff, 1'b1, CHK_MODEL, RES_NONE},
    '{8'h00, 1'b1, CHK_MODEL, RES_NONE},
    // a pixel left in flight, dropped by the next register write
    '{8'h42, 1'b0, CHK_MODEL, RES_NONE}
  };

  // random phases: raw register values, extremes included, and word budgets
  int unsigned phase_w [N_PHASES] = '{3, 2, 5, 2, 2047, 7, 1, 16};
  int unsigned phase_h [N_PHASES] = '{3, 2, 4, 8191, 3, 2, 0, 6};
  int unsigned phase_n [N_PHASES] = '{60, 50, 80, 60, 1050, 60, 50, 90};

  // ---------------------------------------------------------------------------
  // result side: random stall, and every taken word checked against the queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected word pixel_out %0d row_end %0b frame_end %0b",
                   $time, out_pixel_out, out_row_end, out_frame_end);
          fails++;
        end else begin
          want = blurred_q.pop_front();
          if ({out_pixel_out, out_row_end, out_frame_end} !== want) begin
            $display("%0t: expected pixel_out %0d row_end %0b frame_end %0b, actual %0d %0b %0b",
                     $time, want.pixel, want.row_end, want.frame_end,
                     out_pixel_out, out_row_end, out_frame_end);
            fails++;
          end
        end
      end
      // stall lengths come from the same mix as the pixel side gaps
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(calm_out);
      end
    end
  end

  // watchdog: nothing moving on any port for too long means a hang
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    fw_reg = FRAME_WIDTH_RST;
    fh_reg = FRAME_HEIGHT_RST;
    foreach (upper_row[k]) upper_row[k] = '0;
    foreach (middle_row[k]) middle_row[k] = '0;
    restart_stream();
    words_fed = 0;
    fails = 0;
    calm_in = 0;
    calm_out = 0;
    stall_left = 0;
    quiet_cycles = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame, reached through out-of-range register values
    cfg_write(REG_FRAME_WIDTH, 32'd0);
    cfg_write(REG_FRAME_HEIGHT, 32'd1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      feed_word(dir_rows[i].pix, dir_rows[i].drn, dir_rows[i].kind, dir_rows[i].want);
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      cfg_write(REG_FRAME_WIDTH, phase_w[p]);
      cfg_write(REG_FRAME_HEIGHT, phase_h[p]);
      run_phase(phase_n[p]);
      settle();
    end

    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/gb3_pkg.sv
rtl/gb3_ram.sv
rtl/gb3_col_cell.sv
rtl/gb3_fifo.sv
rtl/gaussian_blur_3x3_top.sv
dv/gaussian_blur_3x3_top_tb.sv
